/* hw/rtl/lurs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lurs_pkg
// shared types and constants of the lehmer uniform random source
// ----------------------------------------------------------------------------
package lurs_pkg;

    localparam logic [30:0] LCG_MOD     = 31'h7FFF_FFFF;
    localparam logic [14:0] LCG_MULT    = 15'd16807;
    localparam logic [30:0] STATE_RESET = 31'd65521;
    localparam logic [30:0] SEED_MIN    = 31'd1;
    localparam logic [30:0] SEED_MAX    = 31'h7FFF_FFFE;

    // multiples of the frac divisor 2^31-2, used to correct 2*(x-1)
    localparam logic [32:0] FRAC_D1 = 33'h0_7FFF_FFFE;
    localparam logic [32:0] FRAC_D2 = 33'h0_FFFF_FFFC;
    localparam logic [32:0] FRAC_D3 = 33'h1_7FFF_FFFA;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic REG_END_A = 1'b0;
    localparam logic REG_END_B = 1'b1;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic        load;
        logic [30:0] seed;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] end_a;
        logic signed [31:0] end_b;
    } t_cfg;

endpackage : lurs_pkg
`default_nettype wire

/* hw/rtl/lurs_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lurs_regs
// apb register file holding the two ends of the output interval
// ----------------------------------------------------------------------------
module lurs_regs #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output lurs_pkg::t_cfg     o_cfg
);
    import lurs_pkg::*;

    localparam logic [31:0] END_B_RESET = 32'(1) << FRAC_BITS;

    logic [31:0] r_end_a;
    logic [31:0] r_end_b;
    logic        wr_en;

    assign wr_en  = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_a <= 32'd0;
            r_end_b <= END_B_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_END_A: r_end_a <= pwdata;
                REG_END_B: r_end_b <= pwdata;
                default:   r_end_a <= r_end_a;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_END_A: prdata = r_end_a;
            REG_END_B: prdata = r_end_b;
            default:   prdata = 32'd0;
        endcase
    end

    assign o_cfg.end_a = r_end_a;
    assign o_cfg.end_b = r_end_b;

endmodule : lurs_regs
`default_nettype wire

/* hw/rtl/lurs_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lurs_front
// accepts input words, decodes the opcode and clamps load seeds
// ----------------------------------------------------------------------------
module lurs_front (
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [31:0]   s_tdata,   // seed_in
    input  wire logic          s_tuser,   // opcode
    input  wire logic          i_q_full,
    output logic               o_push,
    output lurs_pkg::t_cmd     o_cmd
);
    import lurs_pkg::*;

    logic [30:0] seed_clamped;

    always_comb begin
        priority if (s_tdata[31] || (s_tdata == 32'd0)) begin
            seed_clamped = SEED_MIN;
        end else if (s_tdata[30:0] == LCG_MOD) begin
            seed_clamped = SEED_MAX;
        end else begin
            seed_clamped = s_tdata[30:0];
        end
    end

    assign s_tready   = ~i_q_full;
    assign o_push     = s_tvalid & ~i_q_full;
    assign o_cmd.load = (s_tuser == OP_LOAD);
    assign o_cmd.seed = seed_clamped;

endmodule : lurs_front
`default_nettype wire

/* hw/rtl/lurs_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lurs_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module lurs_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  lurs_pkg::t_cmd     i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output lurs_pkg::t_cmd     o_cmd
);
    import lurs_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule : lurs_queue
`default_nettype wire

/* hw/rtl/lurs_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lurs_back
// generator state, multiply and fold, uniform scaling and output register
// ----------------------------------------------------------------------------
module lurs_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  lurs_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    input  lurs_pkg::t_cfg     i_cfg,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata    // raw_value, uniform_value, zero pad
);
    import lurs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_FRAC,
        ST_SCALE,
        ST_OUT
    } t_state;

    t_state      r_state;
    logic [30:0] r_x;
    logic [45:0] r_prod;
    logic [31:0] r_frac;
    logic [31:0] r_lo;
    logic [31:0] r_diff;
    logic [31:0] r_offs;
    logic        r_m_valid;
    logic [30:0] r_m_raw;
    logic [31:0] r_m_uni;

    logic [31:0] fold_sum;
    logic [30:0] n_x;
    logic [30:0] y;
    logic [32:0] y4;
    logic [1:0]  frac_q;
    logic [31:0] n_frac;
    logic [32:0] ends_diff;
    logic        a_lt_b;
    logic [63:0] scale_prod;
    logic        out_free;
    logic        out_load;

    // mersenne fold of the product
    always_comb begin
        fold_sum = 32'(r_prod[45:31]) + 32'(r_prod[30:0]);
        if (fold_sum >= 32'(LCG_MOD)) begin
            n_x = 31'(fold_sum - 32'(LCG_MOD));
        end else begin
            n_x = fold_sum[30:0];
        end
    end

    // frac = 2*(x-1) + floor(4*(x-1) / (2^31-2))
    always_comb begin
        y      = r_x - 31'd1;
        y4     = {y, 2'b00};
        frac_q = 2'(y4 >= FRAC_D1) + 2'(y4 >= FRAC_D2) + 2'(y4 >= FRAC_D3);
        n_frac = {y, 1'b0} + 32'(frac_q);
    end

    always_comb begin
        a_lt_b    = (i_cfg.end_a < i_cfg.end_b);
        ends_diff = a_lt_b ? (33'(i_cfg.end_b) - 33'(i_cfg.end_a))
                           : (33'(i_cfg.end_a) - 33'(i_cfg.end_b));
    end

    assign scale_prod = 64'(r_diff) * 64'(r_frac);
    assign out_free   = ~r_m_valid | m_tready;
    assign out_load   = (r_state == ST_OUT) & out_free;
    assign o_pop      = (r_state == ST_IDLE) & i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_x       <= STATE_RESET;
            r_m_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        if (i_cmd.load) begin
                            r_x <= i_cmd.seed;
                        end else begin
                            r_prod  <= 46'(r_x) * 46'(LCG_MULT);
                            r_state <= ST_FOLD;
                        end
                    end
                end
                ST_FOLD: begin
                    r_x     <= n_x;
                    r_state <= ST_FRAC;
                end
                ST_FRAC: begin
                    r_frac  <= n_frac;
                    r_lo    <= a_lt_b ? i_cfg.end_a : i_cfg.end_b;
                    r_diff  <= ends_diff[31:0];
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    r_offs  <= scale_prod[63:32];
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_m_raw   <= r_x;
                        r_m_uni   <= r_lo + r_offs;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {1'b0, r_m_uni, r_m_raw};

endmodule : lurs_back
`default_nettype wire

/* hw/rtl/lehmer_uniform_random_source_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lehmer_uniform_random_source_unit
// minimal standard lcg (16807 mod 2^31-1) with a scaled uniform output
// ----------------------------------------------------------------------------
// input stream: s_tuser is the opcode (0 draw, 1 load seed), s_tdata the seed.
// a load word sets the generator state (clamped to 1 .. 2^31-2) and gives
// no output word. a draw word advances the state and gives one output word:
// m_tdata[30:0] the new state, m_tdata[62:31] the uniform sample in
// [min(end_a,end_b), max(end_a,end_b)) as signed fixed point.
// apb port: end_a at address 0, end_b at address 4, write only while idle.
// input words enter a two-entry queue, so s_tready drops only when it is full.
// a draw passes through the five steps of the back sequencer (multiply,
// fold, frac, scale multiply, output) before m_tvalid rises; a load only
// sets the state. the sequencer takes no new word until a draw is done.
// the output register holds a finished word while m_tready is low; the
// sequencer then waits in its output step and the queue fills up.
// reset clears the queue, the output valid and sets the state to 65521,
// end_a to 0 and end_b to 1.0.
// ----------------------------------------------------------------------------
module lehmer_uniform_random_source_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [31:0]   s_tdata,   // seed_in
    input  wire logic          s_tuser,   // opcode
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata,   // raw_value, uniform_value, zero pad
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import lurs_pkg::*;

    t_cfg cfg;
    t_cmd front_cmd;
    t_cmd q_cmd;
    logic push;
    logic q_full;
    logic q_valid;
    logic pop;

    lurs_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lurs_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    lurs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    lurs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .i_cfg     (cfg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule : lehmer_uniform_random_source_unit
`default_nettype wire
